[rtl/segmented_prime_sieve_unit_defines.svh]
// Assertion macros for the port-level checker
`ifndef SEGMENTED_PRIME_SIEVE_UNIT_DEFINES_SVH
`define SEGMENTED_PRIME_SIEVE_UNIT_DEFINES_SVH
// implication checked each clock, off during reset
`define SPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, off during reset
`define SPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared constants for the segmented prime sieve.
// ----------------------------------------------------------------------------
package sps_pkg;
  localparam int unsigned SMALL_BOUND   = 31622;
  localparam int unsigned WINDOW        = 64;
  localparam int unsigned TABLE_DEPTH   = 4096;
  localparam int unsigned MAX_RESULTS   = 18;
  localparam int unsigned VAL_W         = 30;
  localparam logic [29:0] LIMIT_RESET   = 30'd1000000000;
endpackage

[rtl/sps_ram.sv]
// ----------------------------------------------------------------------------
// sps_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sps_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/sps_div.sv]
// ----------------------------------------------------------------------------
// sps_div
// Restoring divider: 30-bit dividend by 15-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module sps_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [29:0] dividend,
  input  logic [14:0] divisor,
  output logic        done,
  output logic [14:0] rem
);
  logic [29:0] q_r;
  logic [15:0] r_r;
  logic [14:0] d_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [15:0] sh;
  logic [16:0] diff;

  always_comb begin
    sh   = {r_r[14:0], q_r[29]};
    diff = {1'b0, sh} - {2'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        r_r    <= '0;
        d_r    <= divisor;
        cnt_r  <= 5'd29;
      end else if (busy_r) begin
        if (diff[16]) begin
          r_r <= sh;
          q_r <= {q_r[28:0], 1'b0};
        end else begin
          r_r <= diff[15:0];
          q_r <= {q_r[28:0], 1'b1};
        end
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign rem  = r_r[14:0];
endmodule

[rtl/segmented_prime_sieve_unit.sv]
// ----------------------------------------------------------------------------
// segmented_prime_sieve_unit
// Builds a small-prime table after reset, then sieves one window per request.
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// in       in   in_valid/in_ready     in_window_base
// out      out  out_valid/out_ready   out_prime_value, out_valid_res, out_last
// cfg      in   cfg_we                cfg_data (upper_limit)
// Build after reset: set every flag, clear the multiples of each prime up to
// sqrt(SMALL_BOUND), then collect the table; in_ready is low until done.
// Per window: for each table prime, read it, take the base modulo it in the
// divider and clear its multiples in the window, then scan the window.
// Output stalls hold the scan; the next request waits for the last result.
// ----------------------------------------------------------------------------
module segmented_prime_sieve_unit #(
  parameter int unsigned SMALL_BOUND = sps_pkg::SMALL_BOUND,
  parameter int unsigned WINDOW      = sps_pkg::WINDOW,
  parameter int unsigned TABLE_DEPTH = sps_pkg::TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [29:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [29:0] in_window_base,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [29:0] out_prime_value,
  output logic        out_valid_res,
  output logic        out_last
);
  localparam int unsigned BD = SMALL_BOUND + 1;
  localparam int unsigned BA = $clog2(BD);
  localparam int unsigned TA = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WA = $clog2(WINDOW);
  localparam logic [15:0] SB = 16'(SMALL_BOUND);
  localparam logic [4:0]  MAXR = 5'(sps_pkg::MAX_RESULTS);

  typedef enum logic [3:0] {
    S_INIT, S_BI, S_BRD, S_BCHK, S_BMRK, S_COL, S_IDLE,
    S_TRD, S_TP, S_DIV, S_MARK, S_SCAN, S_EMPTY
  } state_t;
  state_t st_r;

  logic [29:0] limit_r;
  logic [BA-1:0] b_addr;
  logic          b_we, b_wd, b_rd;
  logic [TA-1:0] t_addr;
  logic          t_we;
  logic [14:0]   t_wd, t_rd;

  logic [15:0] i_r, j_r;
  logic [CW-1:0] cnt_r, k_r;
  logic [29:0] base_r, high_r;
  logic [14:0] p_r;
  logic [30:0] mj_r;
  logic [WINDOW-1:0] bm_r;
  logic [WA:0] s_r;
  logic [4:0]  n_r;
  logic [29:0] pv_r;
  logic        div_go, div_done;
  logic [14:0] drm;
  logic [29:0] pp;
  logic [30:0] mfirst;
  logic [30:0] jv;
  logic        out_free, scan_end, scan_hit, res_ld;

  // collection reads flag i in the cycle after addressing it
  logic col_v_r;
  logic [15:0] col_i_r;

  sps_ram #(.WIDTH(1), .DEPTH(BD)) u_bmap (
    .clk(clk), .we(b_we), .addr(b_addr), .wdata(b_wd), .rdata(b_rd));
  sps_ram #(.WIDTH(15), .DEPTH(TABLE_DEPTH)) u_tab (
    .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));
  sps_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .dividend(base_r), .divisor(t_rd),
    .done(div_done), .rem(drm));

  always_comb begin
    b_we = 1'b0; b_wd = 1'b0; b_addr = j_r[BA-1:0];
    t_we = 1'b0; t_wd = col_i_r[14:0]; t_addr = k_r[TA-1:0];
    unique case (st_r)
      S_INIT: begin b_we = 1'b1; b_wd = 1'b1; end
      S_BRD:  b_addr = i_r[BA-1:0];
      S_BMRK: begin b_we = 1'b1; b_wd = 1'b0; end
      S_COL: begin
        // flag of col_i_r is on b_rd; store it at the next free slot
        b_addr = i_r[BA-1:0];
        t_addr = cnt_r[TA-1:0];
        t_we   = col_v_r && b_rd && (cnt_r < CW'(TABLE_DEPTH));
      end
      default: ;
    endcase
  end

  assign pp     = 30'(p_r) * 30'(p_r);
  // first multiple at or above base
  assign mfirst = (drm == 15'd0) ? {1'b0, base_r} : {1'b0, base_r - 30'(drm)} + 31'(p_r);
  assign jv     = {1'b0, base_r} + 31'(s_r);
  assign div_go = (st_r == S_TP);
  assign in_ready = (st_r == S_IDLE) && !out_valid;

  assign out_free = !out_valid || out_ready;
  assign scan_end = (jv > 31'(high_r)) || (n_r == MAXR);
  assign scan_hit = bm_r[s_r[WA-1:0]] && (jv > 31'd1);
  // a found value is held back one hit so the final one can carry last
  assign res_ld   = out_free &&
                    (((st_r == S_SCAN) && (n_r != 5'd0) && (scan_end || scan_hit)) ||
                     (st_r == S_EMPTY));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT;
      limit_r <= sps_pkg::LIMIT_RESET;
      j_r <= '0; i_r <= '0; cnt_r <= '0; k_r <= '0;
      out_valid <= 1'b0; col_v_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_data;
      if (res_ld) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_INIT: begin
          if (j_r == SB) begin
            i_r <= 16'd2; st_r <= S_BI;
          end else j_r <= j_r + 16'd1;
        end
        S_BI: begin
          if (32'(i_r) * 32'(i_r) > 32'(SB)) begin
            i_r <= 16'd2; cnt_r <= '0; col_v_r <= 1'b0; st_r <= S_COL;
          end else st_r <= S_BRD;
        end
        S_BRD: st_r <= S_BCHK;
        S_BCHK: begin
          if (b_rd) begin
            j_r <= 16'(32'(i_r) * 32'(i_r)); st_r <= S_BMRK;
          end else begin
            i_r <= i_r + 16'd1; st_r <= S_BI;
          end
        end
        S_BMRK: begin
          if (17'(j_r) + 17'(i_r) > 17'(SB)) begin
            i_r <= i_r + 16'd1; st_r <= S_BI;
          end else j_r <= j_r + i_r;
        end
        S_COL: begin
          col_v_r <= (i_r <= SB);
          col_i_r <= i_r;
          if (i_r <= SB) i_r <= i_r + 16'd1;
          if (col_v_r && b_rd && cnt_r < CW'(TABLE_DEPTH)) begin
            cnt_r <= cnt_r + 1'b1;
          end
          if (!col_v_r && i_r > SB) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            base_r <= in_window_base;
            bm_r <= '1; k_r <= '0; s_r <= '0; n_r <= '0;
            if (in_window_base > limit_r) st_r <= S_EMPTY;
            else begin
              high_r <= (31'(in_window_base) + 31'(WINDOW - 1) > 31'(limit_r))
                        ? limit_r : 30'(31'(in_window_base) + 31'(WINDOW - 1));
              st_r <= (cnt_r == '0) ? S_SCAN : S_TRD;
            end
          end
        end
        S_TRD: st_r <= S_TP;
        S_TP: begin
          p_r <= t_rd; st_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            mj_r <= (mfirst > 31'(pp)) ? mfirst : 31'(pp);
            st_r <= S_MARK;
          end
        end
        S_MARK: begin
          if (mj_r > 31'(high_r)) begin
            k_r <= k_r + 1'b1;
            st_r <= (k_r + 1'b1 == cnt_r) ? S_SCAN : S_TRD;
          end else begin
            bm_r[WA'(mj_r - 31'(base_r))] <= 1'b0;
            mj_r <= mj_r + 31'(p_r);
          end
        end
        S_SCAN: begin
          if (out_free) begin
            if (scan_end) begin
              if (n_r == 5'd0) st_r <= S_EMPTY;
              else begin
                out_last <= 1'b1;
                out_prime_value <= pv_r; out_valid_res <= 1'b1;
                st_r <= S_IDLE;
              end
            end else begin
              if (scan_hit) begin
                if (n_r != 5'd0) begin
                  out_last <= 1'b0;
                  out_prime_value <= pv_r; out_valid_res <= 1'b1;
                end
                pv_r <= jv[29:0];
                n_r <= n_r + 5'd1;
              end
              s_r <= s_r + 1'b1;
            end
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_last <= 1'b1;
            out_prime_value <= '0; out_valid_res <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/sps_checker.sv]
// ----------------------------------------------------------------------------
// sps_checker
// Port-level checks on the sieve unit.
// ----------------------------------------------------------------------------
`include "segmented_prime_sieve_unit_defines.svh"
module sps_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [29:0] out_prime_value,
  input logic        out_valid_res,
  input logic        out_last
);
  `SPS_ASSERT_IMP(a_empty_zero, clk, rst_n, out_valid && !out_valid_res, out_prime_value == 30'd0 && out_last)
  `SPS_ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_valid, !in_ready)
  `SPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_prime_value))
endmodule

bind segmented_prime_sieve_unit sps_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_prime_value(out_prime_value),
  .out_valid_res(out_valid_res), .out_last(out_last));

[dv/sps_window_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sps_window_checker
// Watches the request and result channels of the segmented prime sieve,
// predicts the prime list of each accepted window and compares in order.
// ----------------------------------------------------------------------------
module sps_window_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [29:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [29:0] in_window_base,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [29:0] out_prime_value,
  input  logic        out_valid_res,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_primes
);
  typedef struct packed {
    logic [29:0] value;
    logic        found;
    logic        last;
  } prime_res_t;

  prime_res_t      prime_q[$];
  int unsigned     tab_primes[$];
  logic [29:0]     limit_reg;

  // plain sieve over the small bound, kept to the table depth
  initial begin
    bit composite[sps_pkg::SMALL_BOUND + 1];
    for (int unsigned i = 2; i * i <= sps_pkg::SMALL_BOUND; i++) begin
      if (!composite[i]) begin
        for (int unsigned j = i * i; j <= sps_pkg::SMALL_BOUND; j += i) composite[j] = 1'b1;
      end
    end
    for (int unsigned i = 2; i <= sps_pkg::SMALL_BOUND; i++) begin
      if (!composite[i] && tab_primes.size() < sps_pkg::TABLE_DEPTH) begin
        tab_primes = {tab_primes, i};
      end
    end
  end

  task automatic predict_window(input logic [29:0] base);
    longint unsigned hi, st, m, p, b;
    logic [63:0]     flags;
    int              n;
    prime_res_t      r;
    b = base;
    n = 0;
    flags = '1;
    if (b <= limit_reg) begin
      hi = b + sps_pkg::WINDOW - 1;
      if (hi > limit_reg) hi = limit_reg;
      foreach (tab_primes[k]) begin
        p = tab_primes[k];
        m = (b + p - 1) / p * p;
        st = p * p;
        if (m > st) st = m;
        for (longint unsigned j = st; j <= hi; j += p) flags[(j - b) & 63] = 1'b0;
      end
      for (longint unsigned j = b; j <= hi && n < sps_pkg::MAX_RESULTS; j++) begin
        if (flags[(j - b) & 63] && j > 1) begin
          r.value = j[29:0];
          r.found = 1'b1;
          r.last  = 1'b0;
          prime_q = {prime_q, r};
          n++;
        end
      end
    end
    if (n == 0) begin
      r = '{value: '0, found: 1'b0, last: 1'b1};
      prime_q = {prime_q, r};
    end else begin
      prime_q[prime_q.size() - 1].last = 1'b1;
    end
  endtask

  // pending_primes counts windows accepted whose last result is not yet taken
  always @(posedge clk) begin
    prime_res_t exp_r;
    if (!rst_n) begin
      limit_reg <= sps_pkg::LIMIT_RESET;
      prime_q.delete();
      fail_count <= 0;
      pending_primes <= 0;
    end else begin
      if (cfg_we) limit_reg <= cfg_data;
      if (in_valid && in_ready) predict_window(in_window_base);
      pending_primes <= pending_primes + ((in_valid && in_ready) ? 1 : 0)
                        - ((out_valid && out_ready && out_last) ? 1 : 0);
      if (out_valid && out_ready) begin
        if (prime_q.size() == 0) begin
          $display("%0t: unexpected result value=%0d found=%0b last=%0b", $time,
                   out_prime_value, out_valid_res, out_last);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = prime_q.pop_front();
          if (exp_r.value !== out_prime_value || exp_r.found !== out_valid_res ||
              exp_r.last !== out_last) begin
            $display("%0t: mismatch expected value=%0d found=%0b last=%0b, got %0d %0b %0b",
                     $time, exp_r.value, exp_r.found, exp_r.last,
                     out_prime_value, out_valid_res, out_last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[dv/tb_segmented_prime_sieve_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_segmented_prime_sieve_unit
// Directed and random window requests across several upper limits, with
// random idling on both channels and one long result hold-off.
// ----------------------------------------------------------------------------
module tb_segmented_prime_sieve_unit;
  localparam int CYCLE_LIMIT = 100_000_000;
  // longer than one full window sieve, so the block fills and stalls input
  localparam int HOLD_CYCLES = 300_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [29:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [29:0] in_window_base = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [29:0] out_prime_value;
  logic        out_valid_res;
  logic        out_last;
  int          fail_count;
  int          pending_primes;
  int          cycle_cnt = 0;
  int          sent = 0;
  bit          steady = 1'b0;
  bit          hold_off = 1'b0;

  always #4 clk = ~clk;

  segmented_prime_sieve_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_window_base(in_window_base),
    .out_valid(out_valid), .out_ready(out_ready), .out_prime_value(out_prime_value),
    .out_valid_res(out_valid_res), .out_last(out_last)
  );

  sps_window_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_window_base(in_window_base),
    .out_valid(out_valid), .out_ready(out_ready), .out_prime_value(out_prime_value),
    .out_valid_res(out_valid_res), .out_last(out_last),
    .fail_count(fail_count), .pending_primes(pending_primes)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[segmented_prime_sieve_unit] ERROR");
      $finish;
    end
  end

  // receiver: random stalls, none while steady, stalled throughout hold-off
  always @(posedge clk) begin
    out_ready <= !hold_off && (steady || $urandom_range(99) >= 22);
  end

  // long hold-off on results while requests keep coming
  initial begin
    wait (sent == 30);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // called at a clock edge; returns at the edge where the request is taken, or after a random idle gap
  task automatic send_window(input logic [29:0] base);
    in_valid       <= 1'b1;
    in_window_base <= base;
    do @(posedge clk); while (!in_ready);
    sent++;
    if (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic set_limit(input logic [29:0] lim);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_primes != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    logic [29:0] base;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= 30'd1000000000;
    @(posedge clk);
    cfg_we   <= 1'b0;

    // full range: first window holds exactly the max result count
    send_window(30'd0);
    send_window(30'd1);
    send_window(30'd2);
    send_window(30'd63);
    send_window(30'd31600);
    send_window(30'd436273010);          // inside a long prime gap
    send_window(30'd999950880);          // around the small bound squared
    send_window(30'd999999937);
    send_window(30'd1000000000);         // clipped to a single number
    send_window(30'd1000000001);         // above the limit
    send_window(30'h3FFFFFFF);

    set_limit(30'd2);
    send_window(30'd0);
    send_window(30'd2);
    send_window(30'd3);

    set_limit(30'd100);
    send_window(30'd50);
    send_window(30'd97);

    set_limit(30'd999999999);
    send_window(30'd999999990);
    send_window(30'd999999999);

    set_limit(30'($urandom_range(1000, 999999999)));
    for (int i = 0; i < 10; i++) send_window(30'($urandom_range(0, 999999999)));

    set_limit(30'd1000000000);
    for (int i = 0; i < 72; i++) begin
      steady <= (i >= 30 && i < 50);
      case ($urandom_range(3))
        0:       base = 30'($urandom_range(0, 2000));
        1:       base = 30'($urandom_range(999990000, 1000000000));
        default: base = 30'($urandom_range(0, 1000000000));
      endcase
      send_window(base);
    end
    steady <= 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_primes != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("[segmented_prime_sieve_unit] OK");
    end else begin
      $display("[segmented_prime_sieve_unit] ERROR");
    end
    $finish;
  end
endmodule
